// ===== rtl/pair_distance_histogram_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PAIR_DISTANCE_HISTOGRAM_CORE_ASSERT_SVH
`define PAIR_DISTANCE_HISTOGRAM_CORE_ASSERT_SVH

// Same-cycle implication.
`define PDH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PDH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdh_pkg.sv =====
`timescale 1ns / 1ps
package pdh_pkg;

  localparam int COORD_W  = 16;
  localparam int SCALE_W  = 16;
  localparam int COUNT_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int SQ_W     = 2 * COORD_W;      // one squared difference
  localparam int SUM_W    = SQ_W + 2;         // sum of three squares
  localparam int ROOT_W   = SUM_W / 2;        // floor root of the sum
  localparam int PROD_W   = ROOT_W + SCALE_W; // distance times scale
  localparam int BIN_W    = PROD_W - 16;      // bin number after >> 16

  // Highest even power of two below 2^SUM_W; the root search starts here.
  localparam logic [SUM_W-1:0] ROOT_BIT_TOP = SUM_W'(1) << (SUM_W - 2);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  localparam logic KIND_BIN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] first_z;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic [COORD_W-1:0] second_z;
    logic [INDEX_W-1:0] read_bin;
  } pdh_cmd_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] pair_count;
    logic               out_of_range;
  } pdh_result_t;

endpackage

// ===== rtl/pair_distance_histogram_core.sv =====
`timescale 1ns / 1ps
// Pair distance histogram core.
// Command channel: drive cmd and pulse start; the beat is taken at the edge
// where start is high and busy is low. kind selects binning a particle pair
// or reading one histogram bin. Result channel: done strobes for exactly one
// cycle with the result beat; the receiver has no way to hold it off.
// Sequence: a pair beat passes through the squares, the sum, 17 root steps
// and the root's done strobe, the scale multiply, the memory read and the
// write back; one that falls past the last bin ends at the range check with
// no write back. A read beat reads its bin at acceptance and gives its result
// from the readout state. One beat is in flight at a time, so a new command
// is not taken until the last one is through. busy drops in the cycle done
// strobes, so the next command can be taken while the result is on the port.
// Reset: rst clears control and sets bin_scale to 256, then a clearing pass
// writes zero into every bin with busy high. APB writes are taken during the
// pass. bin_scale sits at byte address 0; pready is tied high.
module pair_distance_histogram_core
  import pdh_pkg::*;
#(
  parameter int NUM_BINS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  pdh_cmd_t    cmd,
  output logic        busy,
  output logic        done,
  output pdh_result_t result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_BINS - 1);
  localparam logic [BIN_W-1:0] BIN_LIMIT = BIN_W'(NUM_BINS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_SQR   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_ROOT  = 4'd4;
  localparam logic [3:0] ST_SCALE = 4'd5;
  localparam logic [3:0] ST_CHECK = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_RDOUT = 4'd8;

  // ---------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------
  logic [SCALE_W-1:0] bin_scale;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(bin_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_scale <= SCALE_RESET;
    end else if (cfg_wr) begin
      bin_scale <= pwdata[SCALE_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  logic [3:0]         state;
  logic [AW-1:0]      clear_addr;
  logic               accept;
  logic [COUNT_W-1:0] pairs_seen;

  // datapath registers
  logic [COORD_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]    sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]   sum;
  logic [ROOT_W-1:0]  distance;
  logic               sq_done;
  logic [PROD_W-1:0]  product;
  logic [BIN_W-1:0]   bin;
  logic [INDEX_W-1:0] read_bin;
  logic               read_ok;

  // histogram memory
  logic [COUNT_W-1:0] hist_mem [NUM_BINS];
  logic [AW-1:0]      mem_raddr;
  logic [AW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               mem_we;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] bin_inc;
  logic [COUNT_W-1:0] pairs_inc;
  logic [BIN_W-1:0]   read_wide;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;

  assign sum     = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign product = PROD_W'(distance) * PROD_W'(bin_scale);

  assign read_wide = BIN_W'(cmd.read_bin);
  assign bin_inc   = (rd_data == '1) ? rd_data : rd_data + 1'b1;
  assign pairs_inc = (pairs_seen == '1) ? pairs_seen : pairs_seen + 1'b1;

  // Read address: the requested bin when a read beat comes in, else the
  // computed bin. A read past the table still reads, but its data is dropped.
  assign mem_raddr = (state == ST_IDLE) ? read_wide[AW-1:0] : bin[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bin[AW-1:0];
    mem_wdata = bin_inc;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if (state == ST_UPD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= hist_mem[mem_raddr];
  end

  pdh_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_SUM),
    .radicand (sum),
    .done     (sq_done),
    .root     (distance)
  );

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      pairs_seen <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (cmd.kind == KIND_READ) ? ST_RDOUT : ST_SQR;
          end
        end
        ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_SQR:   state <= ST_SUM;
        ST_SUM:   state <= ST_ROOT;
        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_CHECK;
        ST_CHECK: begin
          if (bin < BIN_LIMIT) begin
            state <= ST_UPD;          // read issued this cycle
          end else begin
            done  <= 1'b1;            // pair beyond the last bin
            state <= ST_IDLE;
          end
        end
        ST_UPD: begin
          pairs_seen <= pairs_inc;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_RDOUT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      dx       <= (cmd.first_x > cmd.second_x) ? cmd.first_x - cmd.second_x
                                               : cmd.second_x - cmd.first_x;
      dy       <= (cmd.first_y > cmd.second_y) ? cmd.first_y - cmd.second_y
                                               : cmd.second_y - cmd.first_y;
      dz       <= (cmd.first_z > cmd.second_z) ? cmd.first_z - cmd.second_z
                                               : cmd.second_z - cmd.first_z;
      read_bin <= cmd.read_bin;
      read_ok  <= read_wide < BIN_LIMIT;
    end
    if (state == ST_SQR) begin
      sq_x <= SQ_W'(dx) * SQ_W'(dx);
      sq_y <= SQ_W'(dy) * SQ_W'(dy);
      sq_z <= SQ_W'(dz) * SQ_W'(dz);
    end
    if (state == ST_SCALE) begin
      bin <= product[PROD_W-1:16];
    end
    if (state == ST_CHECK) begin
      result.bin_index    <= '0;
      result.bin_count    <= '0;
      result.pair_count   <= pairs_seen;
      result.out_of_range <= 1'b1;
    end
    if (state == ST_UPD) begin
      result.bin_index    <= bin[INDEX_W-1:0];
      result.bin_count    <= bin_inc;
      result.pair_count   <= pairs_inc;
      result.out_of_range <= 1'b0;
    end
    if (state == ST_RDOUT) begin
      result.bin_index    <= read_bin;
      result.bin_count    <= read_ok ? rd_data : '0;
      result.pair_count   <= pairs_seen;
      result.out_of_range <= !read_ok;
    end
  end

endmodule

// ===== rtl/pdh_isqrt.sv =====
`timescale 1ns / 1ps
// Floor square root, two radicand bits per cycle.
module pdh_isqrt
  import pdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic             running;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] bitv;
  logic [SUM_W-1:0] trial;

  assign trial = acc + bitv;
  assign root  = acc[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && (bitv >> 2) == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      acc  <= '0;
      bitv <= ROOT_BIT_TOP;
    end else if (running) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== rtl/pdh_checker.sv =====
`timescale 1ns / 1ps
`include "pair_distance_histogram_core_assert.svh"
// Port-level checks on the histogram core.
module pdh_checker
  import pdh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input pdh_result_t result
);

  // an accepted beat keeps the core busy
  `PDH_ASSERT_NXT(a_busy_after_accept, clk, rst, start && !busy, busy, "accept without busy")

  // no result in the cycle right after an acceptance
  `PDH_ASSERT_NXT(a_no_early_done, clk, rst, start && !busy, !done, "result too early")

  // no two result strobes in a row
  `PDH_ASSERT_NXT(a_single_strobe, clk, rst, done, !done, "double result strobe")

  // out-of-range results carry no count
  `PDH_ASSERT_IMP(a_oor_zero, clk, rst, done && result.out_of_range,
                  result.bin_count == '0, "out-of-range result with count")

endmodule

bind pair_distance_histogram_core pdh_checker u_pdh_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
